// ===== rtl/hspd_pkg.sv =====
// Package: shared types, codes and constants of the humidity sensor pulse decoder.
`timescale 1ns / 1ps
package hspd_pkg;

  localparam int FRAME_PULSES = 82;
  localparam int PULSE_IDX_W = $clog2(FRAME_PULSES);
  localparam logic [PULSE_IDX_W-1:0] LAST_PULSE = PULSE_IDX_W'(FRAME_PULSES - 1);
  localparam logic [PULSE_IDX_W-1:0] FIRST_DATA_PULSE = PULSE_IDX_W'(3);
  localparam logic [7:0] PULSE_LIMIT_US = 8'd120;
  localparam int FRAME_BITS = 40;

  localparam logic [7:0] INIT_LOW_MIN_RST = 8'd65;
  localparam logic [7:0] INIT_LOW_MAX_RST = 8'd85;
  localparam logic [7:0] ONE_THRESHOLD_RST = 8'd35;
  localparam logic [15:0] READ_INTERVAL_RST = 16'd2000;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_LOW_MIN  = 2'd0,
    CFG_INIT_LOW_MAX  = 2'd1,
    CFG_ONE_THRESHOLD = 2'd2,
    CFG_READ_INTERVAL = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_PULSE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_FRESH   = 3'd0,
    ST_CACHED  = 3'd1,
    ST_TIMEOUT = 3'd2,
    ST_INIT    = 3'd3,
    ST_CHECK   = 3'd4,
    ST_NODATA  = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0]  init_low_min;
    logic [7:0]  init_low_max;
    logic [7:0]  one_threshold;
    logic [15:0] read_interval_ms;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] now_ms;
    logic [7:0]  pulse_us;
  } item_t;

  typedef struct packed {
    logic        ok;
    status_t     status;
    logic [15:0] temperature_raw;
    logic [15:0] humidity_raw;
  } res_t;

endpackage

// ===== rtl/humidity_sensor_pulse_decoder.sv =====
// Top level of the humidity sensor pulse decoder: ports, config registers, input stage.
//
//  port group | direction | beat contents
//  -----------+-----------+----------------------------------------------
//  in_*       | in        | op, now_ms, pulse_us
//  out_*      | out       | ok, status, temperature_raw, humidity_raw
//  cfg_*      | in        | write enable, register index, 16-bit data
//
// One beat per cycle sustained while out_stall is low. An accepted beat waits in the
// input register until it fires, then the decode logic writes the result register; a
// beat that yields no result leaves the result register empty.
// Synchronous active-low reset clears the frame state, the cache and both valid flags.
// When the input and result registers are both full and out_stall is high, in_stall rises
// in the same cycle.
`timescale 1ns / 1ps
module humidity_sensor_pulse_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_op,
  input  logic [31:0]                     in_now_ms,
  input  logic [7:0]                      in_pulse_us,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_ok,
  output logic [2:0]                      out_status,
  output logic [15:0]                     out_temperature_raw,
  output logic [15:0]                     out_humidity_raw,
  input  logic                            cfg_we,
  input  logic [hspd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hspd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hspd_pkg::*;

  cfg_t  cfg_r;
  logic  s1_valid_r, s1_valid_nxt;
  item_t s1_item_r;
  logic  accept, fire;
  logic  res_valid;
  res_t  res, out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{init_low_min: INIT_LOW_MIN_RST, init_low_max: INIT_LOW_MAX_RST,
                 one_threshold: ONE_THRESHOLD_RST, read_interval_ms: READ_INTERVAL_RST};
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_INIT_LOW_MIN:  cfg_r.init_low_min     <= cfg_wdata[7:0];
        CFG_INIT_LOW_MAX:  cfg_r.init_low_max     <= cfg_wdata[7:0];
        CFG_ONE_THRESHOLD: cfg_r.one_threshold    <= cfg_wdata[7:0];
        CFG_READ_INTERVAL: cfg_r.read_interval_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the input register whenever the result register can take a beat.
  assign fire         = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall     = s1_valid_r && !fire;
  assign accept       = in_valid && !in_stall;
  assign s1_valid_nxt = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= '{op: op_t'(in_op), now_ms: in_now_ms, pulse_us: in_pulse_us};
    end
  end

  hspd_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  hspd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .load_valid (res_valid),
    .load_res   (res),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_res    (out_res)
  );

  assign out_ok              = out_res.ok;
  assign out_status          = out_res.status;
  assign out_temperature_raw = out_res.temperature_raw;
  assign out_humidity_raw    = out_res.humidity_raw;

endmodule

// ===== rtl/hspd_frame.sv =====
// Frame decoder: read-request gating, pulse classification, bit capture and checksum.
`timescale 1ns / 1ps
module hspd_frame (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  hspd_pkg::item_t item,
  input  hspd_pkg::cfg_t  cfg,
  output logic           res_valid,
  output hspd_pkg::res_t  res
);
  import hspd_pkg::*;

  logic                  armed_r, armed_nxt;
  logic [PULSE_IDX_W-1:0] pulse_index_r, pulse_index_nxt;
  logic [FRAME_BITS-1:0] bit_shift_r, bit_shift_nxt;
  logic                  init_bad_r, init_bad_nxt;
  logic [31:0]           last_read_ms_r, last_read_ms_nxt;
  logic                  ever_read_r, ever_read_nxt;
  logic [15:0]           cached_temp_r, cached_temp_nxt;
  logic [15:0]           cached_hum_r, cached_hum_nxt;
  logic                  cached_valid_r, cached_valid_nxt;

  logic [31:0]           elapsed;
  logic                  arm;
  logic                  too_wide;
  logic                  data_pulse;
  logic [FRAME_BITS-1:0] shift_upd;
  logic                  init_out;
  logic [15:0]           hum_w, temp_w;
  logic [7:0]            check_w, sum_w;

  assign elapsed    = item.now_ms - last_read_ms_r;
  assign arm        = !ever_read_r || (elapsed >= {16'd0, cfg.read_interval_ms});
  assign too_wide   = (item.pulse_us == 8'd0) || (item.pulse_us > PULSE_LIMIT_US);
  assign data_pulse = (pulse_index_r >= FIRST_DATA_PULSE) && pulse_index_r[0];
  assign shift_upd  = data_pulse ?
                      {bit_shift_r[FRAME_BITS-2:0], (item.pulse_us >= cfg.one_threshold)} :
                      bit_shift_r;
  assign init_out   = (item.pulse_us < cfg.init_low_min) || (item.pulse_us > cfg.init_low_max);
  assign hum_w      = shift_upd[39:24];
  assign temp_w     = shift_upd[23:8];
  assign check_w    = shift_upd[7:0];
  assign sum_w      = hum_w[15:8] + hum_w[7:0] + temp_w[15:8] + temp_w[7:0];

  always_comb begin
    armed_nxt        = armed_r;
    pulse_index_nxt  = pulse_index_r;
    bit_shift_nxt    = bit_shift_r;
    init_bad_nxt     = init_bad_r;
    last_read_ms_nxt = last_read_ms_r;
    ever_read_nxt    = ever_read_r;
    cached_temp_nxt  = cached_temp_r;
    cached_hum_nxt   = cached_hum_r;
    cached_valid_nxt = cached_valid_r;
    res_valid        = 1'b0;
    res              = '{ok: 1'b0, status: ST_NODATA, temperature_raw: 16'd0,
                         humidity_raw: 16'd0};
    if (item.op == OP_READ) begin
      // A request always drops any frame in progress.
      armed_nxt = arm;
      if (arm) begin
        pulse_index_nxt  = '0;
        bit_shift_nxt    = '0;
        init_bad_nxt     = 1'b0;
        last_read_ms_nxt = item.now_ms;
        ever_read_nxt    = 1'b1;
      end else begin
        res_valid = 1'b1;
        if (cached_valid_r) begin
          res = '{ok: 1'b1, status: ST_CACHED, temperature_raw: cached_temp_r,
                  humidity_raw: cached_hum_r};
        end
      end
    end else if (armed_r) begin
      if (too_wide) begin
        armed_nxt     = 1'b0;
        res_valid     = 1'b1;
        res.status    = ST_TIMEOUT;
      end else begin
        if (pulse_index_r == '0) begin
          init_bad_nxt = init_bad_r | init_out;
        end
        bit_shift_nxt = shift_upd;
        if (pulse_index_r != LAST_PULSE) begin
          pulse_index_nxt = pulse_index_r + 1'b1;
        end else begin
          armed_nxt       = 1'b0;
          pulse_index_nxt = '0;
          res_valid       = 1'b1;
          if (init_bad_r) begin
            res.status = ST_INIT;
          end else if (sum_w != check_w) begin
            res.status = ST_CHECK;
          end else begin
            cached_temp_nxt  = temp_w;
            cached_hum_nxt   = hum_w;
            cached_valid_nxt = 1'b1;
            res = '{ok: 1'b1, status: ST_FRESH, temperature_raw: temp_w,
                    humidity_raw: hum_w};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r        <= 1'b0;
      pulse_index_r  <= '0;
      bit_shift_r    <= '0;
      init_bad_r     <= 1'b0;
      last_read_ms_r <= '0;
      ever_read_r    <= 1'b0;
      cached_temp_r  <= '0;
      cached_hum_r   <= '0;
      cached_valid_r <= 1'b0;
    end else if (fire) begin
      armed_r        <= armed_nxt;
      pulse_index_r  <= pulse_index_nxt;
      bit_shift_r    <= bit_shift_nxt;
      init_bad_r     <= init_bad_nxt;
      last_read_ms_r <= last_read_ms_nxt;
      ever_read_r    <= ever_read_nxt;
      cached_temp_r  <= cached_temp_nxt;
      cached_hum_r   <= cached_hum_nxt;
      cached_valid_r <= cached_valid_nxt;
    end
  end

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_index_r <= LAST_PULSE)
    else $error("pulse index ran past the frame");

  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_valid && res.ok) |-> (res.status == ST_FRESH || res.status == ST_CACHED))
    else $error("ok result with failure status");

  a_fresh_caches: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_valid && res.status == ST_FRESH) |=> cached_valid_r)
    else $error("fresh reading not cached");

  a_arm_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.op == OP_READ && arm) |=> (armed_r && pulse_index_r == '0 && ever_read_r))
    else $error("arming request did not start a frame");

endmodule

// ===== rtl/hspd_out_reg.sv =====
// Result register: holds one result beat until the consumer takes it.
`timescale 1ns / 1ps
module hspd_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  logic           load_valid,
  input  hspd_pkg::res_t  load_res,
  input  logic           out_stall,
  output logic           out_valid,
  output hspd_pkg::res_t  out_res
);
  import hspd_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  // Hold while stalled, drop once taken, refill on load.
  assign valid_nxt = load ? load_valid : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
